/* hw/rtl/sprq_pkg.sv */
// shared types, codes and sizes for the sorted priority ready queue
`default_nettype none

package sprq_pkg;

  // default number of slots; one is kept free, so capacity is slots minus one
  localparam int QUEUE_SLOTS_DEF = 128;

  // field widths
  localparam int CMD_W  = 2;
  localparam int ID_W   = 7;
  localparam int PRIO_W = 8;
  localparam int STAT_W = 2;
  localparam int OCC_W  = 7;

  // command codes
  localparam logic [CMD_W-1:0] CMD_ENQ    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_POP    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL     = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY    = 2'd2;
  localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd3;

  // one stored entry: id in the upper bits, priority in the lower
  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [PRIO_W-1:0] prio;
  } entry_t;

  // finished command handed from the engine to the output stage
  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [ID_W-1:0]   rid;
    logic [OCC_W-1:0]  occ;
  } result_t;

endpackage

`default_nettype wire

/* hw/rtl/sorted_priority_ready_queue.sv */
// top level of the sorted priority ready queue: handshakes and output register
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  in      | in_valid, in_ready, command, task_id,     | to block
//          | priority_req                              |
//  out     | out_valid, out_ready, status, result_id,  | from block
//          | occupancy                                 |
//
// one command at a time; enqueue, pop and remove step through the queued
// entries: the single memory read port walks or shifts one entry per cycle.
// full, empty and unused commands go straight to the finish state.
// rst is synchronous; it empties the queue, memory contents are left as is.
// a result waits in the output register while out_ready is low; the next
// item is taken once the engine is idle, and it completes only after the
// previous result has been taken.
`default_nettype none

module sorted_priority_ready_queue
  import sprq_pkg::*;
#(
  parameter int QUEUE_SLOTS = QUEUE_SLOTS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [CMD_W-1:0]  command,
  input  wire logic [ID_W-1:0]   task_id,
  input  wire logic [PRIO_W-1:0] priority_req,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [STAT_W-1:0]      status,
  output logic [ID_W-1:0]        result_id,
  output logic [OCC_W-1:0]       occupancy
);

  logic    eng_idle;
  logic    eng_done;
  logic    take;
  result_t eng_res;

  // engine owns the entry memory and the walk over it
  sprq_engine #(
    .QUEUE_SLOTS (QUEUE_SLOTS)
  ) u_engine (
    .clk          (clk),
    .rst          (rst),
    .start        (in_valid),
    .command      (command),
    .task_id      (task_id),
    .priority_req (priority_req),
    .idle         (eng_idle),
    .done         (eng_done),
    .res          (eng_res),
    .take         (take)
  );

  assign in_ready = eng_idle;
  assign take     = eng_done && (!out_valid || out_ready);

  // output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (take) begin
      status    <= eng_res.status;
      result_id <= eng_res.rid;
      occupancy <= eng_res.occ;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/sprq_engine.sv */
// entry memory and sequencer that inserts, scans and shifts one entry a cycle
`default_nettype none

module sprq_engine
  import sprq_pkg::*;
#(
  parameter int QUEUE_SLOTS = QUEUE_SLOTS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [CMD_W-1:0]  command,
  input  wire logic [ID_W-1:0]   task_id,
  input  wire logic [PRIO_W-1:0] priority_req,
  output logic                   idle,
  output logic                   done,
  output result_t                res,
  input  wire logic              take
);

  localparam int DEPTH  = QUEUE_SLOTS - 1;
  localparam int CNT_W  = $clog2(QUEUE_SLOTS);
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [CNT_W-1:0] CAP = CNT_W'(DEPTH);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_ENQ_CMP = 3'd1;
  localparam logic [2:0] S_ENQ_PUT = 3'd2;
  localparam logic [2:0] S_SCAN    = 3'd3;
  localparam logic [2:0] S_SHIFT   = 3'd4;
  localparam logic [2:0] S_FIN     = 3'd5;

  logic [2:0]        state, state_next;
  logic [CNT_W-1:0]  k, k_next;
  logic [CNT_W-1:0]  count, count_next;
  logic [CMD_W-1:0]  cmd_r;
  logic [ID_W-1:0]   id_r;
  logic [PRIO_W-1:0] prio_r;
  logic [STAT_W-1:0] res_status, res_status_next;
  logic [ID_W-1:0]   res_id, res_id_next;

  entry_t            mem [DEPTH];
  entry_t            rdata;
  entry_t            wdata;
  entry_t            new_entry;
  logic              wr_en;
  logic [ADDR_W-1:0] waddr;
  logic [ADDR_W-1:0] raddr;

  // shared index arithmetic
  logic [CNT_W:0]    kx, kp1, kp2, countx;
  logic [CNT_W-1:0]  km1, km2, cm1, cp1;
  logic              match;
  logic [CNT_W+OCC_W-1:0] occ_wide;

  assign kx     = {1'b0, k};
  assign kp1    = kx + (CNT_W+1)'(1);
  assign kp2    = kx + (CNT_W+1)'(2);
  assign countx = {1'b0, count};
  assign km1    = k - CNT_W'(1);
  assign km2    = k - CNT_W'(2);
  assign cm1    = count - CNT_W'(1);
  assign cp1    = count + CNT_W'(1);

  assign new_entry = '{id: id_r, prio: prio_r};
  assign match     = (cmd_r == CMD_POP) || (rdata.id == id_r);

  // entry memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  // sequencer next state
  always_comb begin
    state_next      = state;
    k_next          = k;
    count_next      = count;
    res_status_next = res_status;
    res_id_next     = res_id;
    wr_en           = 1'b0;
    waddr           = ADDR_W'(k);
    wdata           = new_entry;
    raddr           = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          res_status_next = ST_OK;
          res_id_next     = '0;
          case (command)
            CMD_ENQ: begin
              if (count >= CAP) begin
                res_status_next = ST_FULL;
                state_next      = S_FIN;
              end else begin
                k_next = count;
                raddr  = ADDR_W'(cm1);
                if (count == '0) begin
                  state_next = S_ENQ_PUT;
                end else begin
                  state_next = S_ENQ_CMP;
                end
              end
            end
            CMD_POP, CMD_REMOVE: begin
              if (count == '0) begin
                res_status_next = ST_EMPTY;
                state_next      = S_FIN;
              end else begin
                k_next     = '0;
                state_next = S_SCAN;
              end
            end
            default: state_next = S_FIN;
          endcase
        end
      end
      // rdata holds entry k-1; move it up while it ranks below the new one
      S_ENQ_CMP: begin
        wr_en = 1'b1;
        if (rdata.prio < prio_r) begin
          wdata  = rdata;
          k_next = km1;
          raddr  = ADDR_W'(km2);
          if (km1 == '0) begin
            state_next = S_ENQ_PUT;
          end
        end else begin
          count_next = cp1;
          state_next = S_FIN;
        end
      end
      S_ENQ_PUT: begin
        wr_en      = 1'b1;
        count_next = cp1;
        state_next = S_FIN;
      end
      // rdata holds entry k; look for the id, or take the head on pop
      S_SCAN: begin
        raddr = kp1[ADDR_W-1:0];
        if (match) begin
          res_id_next = rdata.id;
          if (kp1 < countx) begin
            state_next = S_SHIFT;
          end else begin
            count_next = cm1;
            state_next = S_FIN;
          end
        end else if (kp1 < countx) begin
          k_next = kp1[CNT_W-1:0];
        end else begin
          res_status_next = ST_NOTFOUND;
          state_next      = S_FIN;
        end
      end
      // rdata holds entry k+1; close the gap one entry a cycle
      S_SHIFT: begin
        wr_en  = 1'b1;
        wdata  = rdata;
        k_next = kp1[CNT_W-1:0];
        raddr  = kp2[ADDR_W-1:0];
        if (kp2 >= countx) begin
          count_next = cm1;
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        if (take) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    k          <= k_next;
    res_status <= res_status_next;
    res_id     <= res_id_next;
    if (start && state == S_IDLE) begin
      cmd_r  <= command;
      id_r   <= task_id;
      prio_r <= priority_req;
    end
  end

  // result toward the output stage
  assign occ_wide   = {{OCC_W{1'b0}}, count};
  assign idle       = (state == S_IDLE);
  assign done       = (state == S_FIN);
  assign res.status = res_status;
  assign res.rid    = res_id;
  assign res.occ    = occ_wide[OCC_W-1:0];

  // count stays within capacity
  a_count_cap: assert property (@(posedge clk) disable iff (rst) count <= CAP)
    else $error("entry count above capacity");

  // memory writes only from insert and shift states
  a_wr_state: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (state == S_ENQ_CMP || state == S_ENQ_PUT || state == S_SHIFT))
    else $error("memory write outside insert or shift");

  // enqueue on a full queue finishes at once with full status
  a_full: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && start && command == CMD_ENQ && count == CAP)
    |=> (state == S_FIN && res_status == ST_FULL && $stable(count)))
    else $error("full enqueue not reported");

  // reset empties the queue
  a_reset: assert property (@(posedge clk) rst |=> (count == '0 && state == S_IDLE))
    else $error("reset did not clear queue");

  // count changes by at most one per command, and only on the way to the end
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (count != $past(count)) |-> (state == S_FIN && $past(state) != S_FIN))
    else $error("count changed outside completion");

endmodule

`default_nettype wire

/* tb/queue_order_checker.sv */
`timescale 1ns / 100ps
// checker for the sorted priority ready queue: shadow queue, expected results and comparison
module queue_order_checker
  import sprq_pkg::*;
#(
  parameter int QUEUE_SLOTS = QUEUE_SLOTS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  input  wire logic              in_ready,
  input  wire logic [CMD_W-1:0]  command,
  input  wire logic [ID_W-1:0]   task_id,
  input  wire logic [PRIO_W-1:0] priority_req,
  input  wire logic              out_valid,
  input  wire logic              out_ready,
  input  wire logic [STAT_W-1:0] status,
  input  wire logic [ID_W-1:0]   result_id,
  input  wire logic [OCC_W-1:0]  occupancy,
  output int                     mismatches,
  output int                     open_results,
  output int                     full_hits,
  output int                     empty_hits,
  output int                     miss_hits
);

  localparam int CAPACITY = QUEUE_SLOTS - 1;

  // shadow copy of the sorted queue
  entry_t  shadow_store [QUEUE_SLOTS];
  int      shadow_count = 0;

  // results still owed by the block, oldest first
  result_t pending_results [$];

  int      fail_n  = 0;
  int      full_n  = 0;
  int      empty_n = 0;
  int      miss_n  = 0;

  // close the gap left by the entry at pos
  function automatic void drop_entry(input int pos);
    int k;
    for (k = pos; k + 1 < shadow_count; k++) begin
      shadow_store[k] = shadow_store[k + 1];
    end
    shadow_count--;
  endfunction

  // apply one command to the shadow queue and return the result it must give
  function automatic result_t queue_outcome(input logic [CMD_W-1:0] cmd,
                                            input logic [ID_W-1:0] id,
                                            input logic [PRIO_W-1:0] prio);
    result_t r;
    int      k;
    int      hit;
    r.status = ST_OK;
    r.rid    = '0;
    case (cmd)
      CMD_ENQ: begin
        if (shadow_count >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          // insert behind every entry of equal or higher priority
          k = shadow_count;
          while (k > 0 && shadow_store[k - 1].prio < prio) begin
            shadow_store[k] = shadow_store[k - 1];
            k--;
          end
          shadow_store[k].id   = id;
          shadow_store[k].prio = prio;
          shadow_count++;
        end
      end
      CMD_POP: begin
        if (shadow_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.rid = shadow_store[0].id;
          drop_entry(0);
        end
      end
      CMD_REMOVE: begin
        if (shadow_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          // first match counted from the head
          hit = -1;
          for (k = 0; k < shadow_count && hit < 0; k++) begin
            if (shadow_store[k].id == id) hit = k;
          end
          if (hit >= 0) begin
            r.rid = id;
            drop_entry(hit);
          end else begin
            r.status = ST_NOTFOUND;
          end
        end
      end
      default: begin
      end
    endcase
    r.occ = shadow_count[OCC_W-1:0];
    return r;
  endfunction

  // watch both channels; results are matched before new items are predicted
  always @(posedge clk) begin
    result_t want;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          $error("result with no item outstanding: status %0d result_id %0d occupancy %0d",
                 status, result_id, occupancy);
          fail_n++;
        end else begin
          want = pending_results.pop_front();
          if (status !== want.status) begin
            $error("status mismatch: expected %0d, actual %0d", want.status, status);
            fail_n++;
          end
          if (result_id !== want.rid) begin
            $error("result_id mismatch: expected %0d, actual %0d", want.rid, result_id);
            fail_n++;
          end
          if (occupancy !== want.occ) begin
            $error("occupancy mismatch: expected %0d, actual %0d", want.occ, occupancy);
            fail_n++;
          end
          if (want.status == ST_FULL) full_n++;
          if (want.status == ST_EMPTY) empty_n++;
          if (want.status == ST_NOTFOUND) miss_n++;
        end
      end
      if (in_valid && in_ready) begin
        pending_results.push_back(queue_outcome(command, task_id, priority_req));
      end
    end
    mismatches   <= fail_n;
    open_results <= pending_results.size();
    full_hits    <= full_n;
    empty_hits   <= empty_n;
    miss_hits    <= miss_n;
  end

endmodule

/* tb/sorted_priority_ready_queue_test.sv */
`timescale 1ns / 100ps
// testbench top for the sorted priority ready queue: clock, reset, stimulus and verdict
module sorted_priority_ready_queue_test;
  import sprq_pkg::*;

  localparam int QUEUE_SLOTS  = QUEUE_SLOTS_DEF;
  localparam int RANDOM_ITEMS = 1100;
  localparam int CYCLE_LIMIT  = 3_000_000;
  localparam int SETTLE_WAIT  = 2 * QUEUE_SLOTS;

  // the command code the block ignores
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  typedef enum int {PH_MIX, PH_FILL, PH_DRAIN} phase_e;

  logic              clk          = 1'b0;
  logic              rst          = 1'b1;
  logic              in_valid     = 1'b0;
  logic              in_ready;
  logic [CMD_W-1:0]  command      = '0;
  logic [ID_W-1:0]   task_id      = '0;
  logic [PRIO_W-1:0] priority_req = '0;
  logic              out_valid;
  logic              out_ready    = 1'b0;
  logic [STAT_W-1:0] status;
  logic [ID_W-1:0]   result_id;
  logic [OCC_W-1:0]  occupancy;

  int mismatches;
  int open_results;
  int full_hits;
  int empty_hits;
  int miss_hits;

  int cycle_count = 0;
  int burst_left  = 0;
  int stall_left  = 0;
  int cmd_count [4];

  always #4 clk = ~clk;

  sorted_priority_ready_queue #(.QUEUE_SLOTS(QUEUE_SLOTS)) dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .command      (command),
    .task_id      (task_id),
    .priority_req (priority_req),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .result_id    (result_id),
    .occupancy    (occupancy)
  );

  queue_order_checker #(.QUEUE_SLOTS(QUEUE_SLOTS)) u_checker (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .command      (command),
    .task_id      (task_id),
    .priority_req (priority_req),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .result_id    (result_id),
    .occupancy    (occupancy),
    .mismatches   (mismatches),
    .open_results (open_results),
    .full_hits    (full_hits),
    .empty_hits   (empty_hits),
    .miss_hits    (miss_hits)
  );

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // receiver: segments of ready or stall of random length, ready more often
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else begin
      stall_left <= $urandom_range(0, 23);
      out_ready  <= ($urandom_range(0, 2) != 0);
    end
  end

  // ids mostly from a narrow range so removes hit and duplicates occur
  function automatic logic [ID_W-1:0] pick_id();
    if ($urandom_range(0, 9) < 7) return ID_W'($urandom_range(0, 15));
    return ID_W'($urandom_range(0, 127));
  endfunction

  // priorities often from a few values so ties are common
  function automatic logic [PRIO_W-1:0] pick_prio();
    case ($urandom_range(0, 9))
      0: return 8'd0;
      1: return 8'd255;
      2: return 8'd128;
      3: return PRIO_W'($urandom_range(1, 3));
      default: return PRIO_W'($urandom_range(0, 255));
    endcase
  endfunction

  // present one item, with burst gaps, and hold it until accepted
  task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [ID_W-1:0] id,
                           input logic [PRIO_W-1:0] prio);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    in_valid     <= 1'b1;
    command      <= cmd;
    task_id      <= id;
    priority_req <= prio;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    cmd_count[cmd]++;
  endtask

  // one random item, weighted by the phase
  task automatic random_item(input phase_e ph);
    int               r;
    logic [CMD_W-1:0] cmd;
    r = $urandom_range(0, 99);
    case (ph)
      PH_FILL:  cmd = (r < 92) ? CMD_ENQ : CMD_POP;
      PH_DRAIN: cmd = (r < 65) ? CMD_POP : (r < 95) ? CMD_REMOVE : CMD_ENQ;
      default:  cmd = (r < 45) ? CMD_ENQ : (r < 70) ? CMD_POP :
                      (r < 95) ? CMD_REMOVE : CMD_UNUSED;
    endcase
    send_item(cmd, pick_id(), pick_prio());
  endtask

  initial begin
    int     sent;
    int     phase_idx;
    int     len;
    phase_e ph;
    sent      = 0;
    phase_idx = 0;
    foreach (cmd_count[i]) cmd_count[i] = 0;

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty queue, extremes, ties, duplicates, misses, unused code
    send_item(CMD_POP, 7'd0, 8'd0);
    send_item(CMD_REMOVE, 7'd5, 8'd0);
    send_item(CMD_UNUSED, 7'd127, 8'd255);
    send_item(CMD_ENQ, 7'd0, 8'd0);
    send_item(CMD_ENQ, 7'd127, 8'd255);
    send_item(CMD_ENQ, 7'd42, 8'd128);
    send_item(CMD_ENQ, 7'd43, 8'd128);
    send_item(CMD_ENQ, 7'd42, 8'd128);
    send_item(CMD_ENQ, 7'd85, 8'd255);
    send_item(CMD_ENQ, 7'd1, 8'd0);
    send_item(CMD_REMOVE, 7'd99, 8'd0);
    send_item(CMD_REMOVE, 7'd42, 8'd77);
    send_item(CMD_UNUSED, 7'd85, 8'd1);
    send_item(CMD_POP, 7'd127, 8'd255);
    send_item(CMD_POP, 7'd0, 8'd0);
    send_item(CMD_REMOVE, 7'd0, 8'd0);
    send_item(CMD_REMOVE, 7'd127, 8'd0);
    send_item(CMD_POP, 7'd0, 8'd0);
    send_item(CMD_POP, 7'd0, 8'd0);
    send_item(CMD_POP, 7'd0, 8'd0);
    send_item(CMD_POP, 7'd0, 8'd0);
    send_item(CMD_REMOVE, 7'd1, 8'd0);

    // random phases; fill and drain phases take the queue to full and empty
    while (sent < RANDOM_ITEMS) begin
      case (phase_idx % 4)
        1: begin
          ph  = PH_FILL;
          len = 150;
        end
        3: begin
          ph  = PH_DRAIN;
          len = 180;
        end
        default: begin
          ph  = PH_MIX;
          len = $urandom_range(60, 120);
        end
      endcase
      repeat (len) begin
        if (sent < RANDOM_ITEMS) begin
          random_item(ph);
          sent++;
        end
      end
      phase_idx++;
    end
    in_valid <= 1'b0;

    // let every owed result arrive, then a quiet stretch
    @(posedge clk);
    while (open_results != 0) @(posedge clk);
    repeat (SETTLE_WAIT) @(posedge clk);

    $display("sent %0d enqueue, %0d pop, %0d remove, %0d unused commands in %0d cycles",
             cmd_count[CMD_ENQ], cmd_count[CMD_POP], cmd_count[CMD_REMOVE],
             cmd_count[CMD_UNUSED], cycle_count);
    $display("queue full %0d times, empty %0d times, id not found %0d times",
             full_hits, empty_hits, miss_hits);
    if (mismatches == 0 && open_results == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
